>>> rtl/rbcq_pkg.sv
// shared types and constants of the roi crop / bilinear resample / quantizer block
// no dependencies; imported by the top level

package rbcq_pkg;

  // default geometry handed to the top level parameters
  localparam int DEF_MAX_SOURCE_WIDTH    = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT   = 256;
  localparam int DEF_COORD_FRACTION_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [8:0]  RST_SRC_W  = 9'd256;
  localparam logic [8:0]  RST_SRC_H  = 9'd256;
  localparam logic [8:0]  RST_OUT_W  = 9'd160;
  localparam logic [8:0]  RST_OUT_H  = 9'd160;
  localparam logic [15:0] RST_MARGIN = 16'd13107;
  localparam logic        RST_SIGNED = 1'b0;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_OUT_W  = 3'd2,
    REG_OUT_H  = 3'd3,
    REG_MARGIN = 3'd4,
    REG_SIGNED = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ROI   = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_SIDE = 4'b0010,
    R_ORG  = 4'b0100,
    R_DIV  = 4'b1000
  } roi_state_e;

  typedef struct packed {
    logic signed [8:0] red;
    logic signed [8:0] green;
    logic signed [8:0] blue;
  } pix_t;

endpackage

>>> rtl/rbcq_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies

module rbcq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/rbcq_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies; used for the crop step computation

module rbcq_div #(
  parameter int NW  = 33,
  parameter int DVW = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic [NW-1:0]  quot_o,
  output logic           done_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DVW-1:0]  rem_q, div_q;
  logic [NW-1:0]   quo_q;
  logic [DVW:0]    rem_sh, rem_nx;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_nx = ge ? rem_sh - {1'b0, div_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_nx[DVW-1:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

>>> rtl/roi_bilinear_crop_quantizer_core.sv
// roi crop, bilinear resample and 8-bit quantizer: top level
// depends on rbcq_pkg, rbcq_ram (frame store) and rbcq_div (step divider)
// pixel path: s1, s2, s3, read sequencer, read tag, m1, m2, result queue (a full queue holds the sequencer)
// pixel requests overlap, their rate set by the single read port of the frame
//   store (four neighbour reads); loads take one beat per cycle when no request is in flight
// a region of interest holds off roi and pixel requests until the serial step divider is
//   done; reset restores register defaults and zero crop, the frame store is not cleared
//   and holds garbage until written

module roi_bilinear_crop_quantizer_core import rbcq_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH    = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT   = DEF_MAX_SOURCE_HEIGHT,
  parameter int COORD_FRACTION_BITS = DEF_COORD_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [7:0]            pos_x_i,
  input  logic [7:0]            pos_y_i,
  input  logic [15:0]           red_in_i,
  input  logic [15:0]           green_in_i,
  input  logic [15:0]           blue_in_i,
  input  logic [15:0]           roi_center_x_i,
  input  logic [15:0]           roi_center_y_i,
  input  logic [15:0]           roi_width_i,
  input  logic [15:0]           roi_height_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [8:0]     red_out_o,
  output logic signed [8:0]     green_out_o,
  output logic signed [8:0]     blue_out_o
);

  localparam int F     = COORD_FRACTION_BITS;
  localparam int XW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int IW    = (XW > YW) ? XW : YW;
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SWW   = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int DMW   = (SWW > SHW) ? SWW : SHW;
  // roi arithmetic widths
  localparam int PW    = 16 + DMW;          // normalized value times frame size
  localparam int SPW   = PW + 18;           // widened side before rounding
  localparam int S15W  = PW + 2;            // side in q.15
  localparam int UPS   = (F >= 16) ? F - 16 : 0;
  localparam int DNS   = (F < 16) ? 16 - F : 0;
  localparam int RND   = (F < 16) ? (1 << ((F < 16) ? 15 - F : 0)) : 0;
  localparam int CW    = S15W + 2 + UPS;
  localparam int CWX   = (CW > 33) ? CW : 33;
  localparam int NDW   = CWX;
  // sample coordinate widths
  localparam int OFW   = 39;
  localparam int SAW   = 41;
  localparam int FLW   = SAW - F;
  // interpolation widths
  localparam int TW    = 16 + F;
  localparam int VW2   = 16 + 2 * F;
  localparam int QS    = 15 + 2 * F;
  localparam int NQW   = VW2 + 10;

  localparam logic signed [CWX-1:0] SMAX = $signed({{(CWX-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [CWX-1:0] SMIN = $signed({{(CWX-31){1'b1}}, {31{1'b0}}});

  // q.16 value to coordinate format
  function automatic logic signed [CWX-1:0] to_coord(input logic signed [CWX-1:0] v);
    logic signed [CWX-1:0] r;
    if (F >= 16) begin
      r = v <<< UPS;
    end else begin
      r = (v + CWX'(RND)) >>> DNS;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [CWX-1:0] v);
    logic signed [31:0] r;
    if (v > SMAX) begin
      r = 32'sh7fffffff;
    end else if (v < SMIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // edge clamp of a neighbour index to 0..lim-1
  function automatic logic [IW-1:0] clamp_idx(input logic signed [FLW-1:0] v,
                                              input logic [DMW-1:0] lim);
    logic signed [FLW-1:0] lim_m1;
    logic [IW-1:0]         r;
    lim_m1 = $signed(FLW'(lim) - FLW'(1));
    if (v < 0) begin
      r = '0;
    end else if (v > lim_m1) begin
      r = IW'(lim_m1);
    end else begin
      r = IW'(v);
    end
    return r;
  endfunction

  // map [0,1] to 8 bits with round half to even and saturation
  function automatic logic signed [8:0] quant(input logic [VW2-1:0] v, input logic sgn);
    logic [NQW-1:0]    n;
    logic [QS-1:0]     r;
    logic [QS-1:0]     half;
    logic [9:0]        q10;
    logic [10:0]       qr;
    logic signed [11:0] t;
    logic signed [8:0] res;
    if (sgn) begin
      n = NQW'(v) * NQW'(254);
    end else begin
      n = NQW'(v) * NQW'(255) + (NQW'(1) << (QS - 1));
    end
    q10  = 10'(n >> QS);
    r    = n[QS-1:0];
    half = QS'(1) << (QS - 1);
    qr   = {1'b0, q10} + 11'((r > half) || ((r == half) && q10[0]));
    if (sgn) begin
      t = $signed({1'b0, qr}) - 12'sd127;
      res = (t > 12'sd127) ? 9'sd127 : 9'(t);
    end else begin
      res = (qr > 11'd255) ? 9'sd255 : $signed(9'(qr));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [8:0]  src_w_q, src_h_q, out_w_q, out_h_q;
  logic [15:0] margin_q;
  logic        sgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= RST_SRC_W;
      src_h_q  <= RST_SRC_H;
      out_w_q  <= RST_OUT_W;
      out_h_q  <= RST_OUT_H;
      margin_q <= RST_MARGIN;
      sgn_q    <= RST_SIGNED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_W:  src_w_q  <= cfg_wdata_i[8:0];
        REG_SRC_H:  src_h_q  <= cfg_wdata_i[8:0];
        REG_OUT_W:  out_w_q  <= cfg_wdata_i[8:0];
        REG_OUT_H:  out_h_q  <= cfg_wdata_i[8:0];
        REG_MARGIN: margin_q <= cfg_wdata_i;
        REG_SIGNED: sgn_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // effective frame and crop sizes
  logic [DMW-1:0] sw_c, sh_c;
  logic [8:0]     ow_c, oh_c;

  always_comb begin
    if (src_w_q == '0) begin
      sw_c = DMW'(1);
    end else if (int'(src_w_q) > MAX_SOURCE_WIDTH) begin
      sw_c = DMW'(MAX_SOURCE_WIDTH);
    end else begin
      sw_c = DMW'(src_w_q);
    end
    if (src_h_q == '0) begin
      sh_c = DMW'(1);
    end else if (int'(src_h_q) > MAX_SOURCE_HEIGHT) begin
      sh_c = DMW'(MAX_SOURCE_HEIGHT);
    end else begin
      sh_c = DMW'(src_h_q);
    end
    ow_c = (out_w_q == '0) ? 9'd1 : out_w_q;
    oh_c = (out_h_q == '0) ? 9'd1 : out_h_q;
  end

  // ---------------------------------------------------------------- input handshake
  logic s1_v_q, s2_v_q, s3_v_q, seq_busy_q;
  logic [1:0] seq_cnt_q;
  logic [OUT_CNT_W-1:0] out_cnt_q, fifo_cnt_q;
  roi_state_e roi_st_q;
  logic s2_ld, s3_ld, seq_take, s1_free, front_idle, roi_idle, in_acc;

  assign front_idle = !s1_v_q && !s2_v_q && !s3_v_q && !seq_busy_q;
  assign roi_idle   = (roi_st_q == R_IDLE);
  assign seq_take   = s3_v_q && (!seq_busy_q || (seq_cnt_q == 2'd3)) &&
                      (out_cnt_q < OUT_CNT_W'(OUT_DEPTH));
  assign s3_ld      = s2_v_q && (!s3_v_q || seq_take);
  assign s2_ld      = s1_v_q && (!s2_v_q || s3_ld);
  assign s1_free    = !s1_v_q || s2_ld;

  // loads wait until no request still has reads to issue, so reads see the older frame
  always_comb begin
    unique case (kind_i)
      KIND_LOAD:  in_ready_o = front_idle;
      KIND_ROI:   in_ready_o = roi_idle && !s1_v_q && !s2_v_q;
      KIND_PIXEL: in_ready_o = roi_idle && s1_free;
      default:    in_ready_o = 1'b1;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- frame store
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [47:0]     ram_rdata;
  logic [AW-1:0]   seq_addr_q [4];

  assign ram_we = in_acc && (kind_i == KIND_LOAD) &&
                  (int'(pos_x_i) < MAX_SOURCE_WIDTH) && (int'(pos_y_i) < MAX_SOURCE_HEIGHT);
  assign ram_waddr = AW'(pos_y_i) * AW'(MAX_SOURCE_WIDTH) + AW'(pos_x_i);
  assign ram_re    = seq_busy_q;
  assign ram_raddr = seq_addr_q[seq_cnt_q];

  rbcq_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- roi setup
  logic [PW-1:0]   cx_q, cy_q, bw_q, bh_q;
  logic [SPW-1:0]  sidep_q;
  logic [S15W-1:0] side15;
  logic [PW-1:0]   side0;
  logic signed [31:0] org_x_q, org_y_q;
  logic [30:0]     step_x_q, step_y_q;
  logic signed [CWX-1:0] val_x, val_y, sidef;
  logic [NDW-1:0]  dvd_x, dvd_y, quo_x, quo_y;
  logic            div_start, div_done_x, div_done_y;

  assign side0  = (bw_q > bh_q) ? bw_q : bh_q;
  assign side15 = sidep_q[SPW-1:16];
  assign val_x  = $signed(CWX'({cx_q, 1'b0})) - $signed(CWX'(side15));
  assign val_y  = $signed(CWX'({cy_q, 1'b0})) - $signed(CWX'(side15));
  assign sidef  = to_coord($signed(CWX'({side15, 1'b0})));
  // rounded division: add half the divisor before the divide
  assign dvd_x  = NDW'($unsigned(sidef)) + NDW'(ow_c >> 1);
  assign dvd_y  = NDW'($unsigned(sidef)) + NDW'(oh_c >> 1);
  assign div_start = (roi_st_q == R_ORG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_st_q <= R_IDLE;
      org_x_q  <= '0;
      org_y_q  <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
    end else begin
      unique case (roi_st_q)
        R_IDLE: begin
          if (in_acc && (kind_i == KIND_ROI)) begin
            roi_st_q <= R_SIDE;
          end
        end
        R_SIDE: roi_st_q <= R_ORG;
        R_ORG: begin
          org_x_q  <= sat32(to_coord(val_x));
          org_y_q  <= sat32(to_coord(val_y));
          roi_st_q <= R_DIV;
        end
        R_DIV: begin
          if (div_done_x) begin
            step_x_q <= (|quo_x[NDW-1:31]) ? {31{1'b1}} : quo_x[30:0];
            step_y_q <= (|quo_y[NDW-1:31]) ? {31{1'b1}} : quo_y[30:0];
            roi_st_q <= R_IDLE;
          end
        end
        default: roi_st_q <= R_IDLE;
      endcase
    end
  end

  // roi payload: frame-scaled region and widened side
  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KIND_ROI)) begin
      cx_q <= PW'(roi_center_x_i) * PW'(sw_c);
      cy_q <= PW'(roi_center_y_i) * PW'(sh_c);
      bw_q <= PW'(roi_width_i) * PW'(sw_c);
      bh_q <= PW'(roi_height_i) * PW'(sh_c);
    end
    if (roi_st_q == R_SIDE) begin
      sidep_q <= SPW'(side0) * SPW'({1'b1, margin_q}) + SPW'(32768);
    end
  end

  rbcq_div #(.NW(NDW), .DVW(9)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_x),
    .divisor_i  (ow_c),
    .quot_o     (quo_x),
    .done_o     (div_done_x)
  );

  rbcq_div #(.NW(NDW), .DVW(9)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_y),
    .divisor_i  (oh_c),
    .quot_o     (quo_y),
    .done_o     (div_done_y)
  );

  // ---------------------------------------------------------------- request front end
  // s1: position, s2: grid offset products, s3: clamped neighbours and weights
  logic [7:0]     s1_px_q, s1_py_q;
  logic [OFW-1:0] s2_offx_q, s2_offy_q;
  logic [XW-1:0]  s3_x0_q, s3_x1_q;
  logic [YW-1:0]  s3_y0_q, s3_y1_q;
  logic [F-1:0]   s3_wx_q, s3_wy_q;
  logic [39:0]    prod_x, prod_y;
  logic signed [SAW-1:0] sx, sy;
  logic signed [FLW-1:0] flx, fly;

  assign prod_x = 40'({s1_px_q, 1'b1}) * 40'(step_x_q);
  assign prod_y = 40'({s1_py_q, 1'b1}) * 40'(step_y_q);
  assign sx  = SAW'(org_x_q) + $signed({2'b00, s2_offx_q});
  assign sy  = SAW'(org_y_q) + $signed({2'b00, s2_offy_q});
  assign flx = sx[SAW-1:F];
  assign fly = sy[SAW-1:F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= (s1_v_q && !s2_ld) || (in_acc && (kind_i == KIND_PIXEL));
      s2_v_q <= (s2_v_q && !s3_ld) || s2_ld;
      s3_v_q <= (s3_v_q && !seq_take) || s3_ld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KIND_PIXEL)) begin
      s1_px_q <= pos_x_i;
      s1_py_q <= pos_y_i;
    end
    if (s2_ld) begin
      s2_offx_q <= prod_x[39:1];
      s2_offy_q <= prod_y[39:1];
    end
    if (s3_ld) begin
      s3_x0_q <= XW'(clamp_idx(flx, sw_c));
      s3_x1_q <= XW'(clamp_idx(flx + FLW'(1), sw_c));
      s3_y0_q <= YW'(clamp_idx(fly, sh_c));
      s3_y1_q <= YW'(clamp_idx(fly + FLW'(1), sh_c));
      s3_wx_q <= sx[F-1:0];
      s3_wy_q <= sy[F-1:0];
    end
  end

  // ---------------------------------------------------------------- read sequencer
  // four reads per request: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
  logic [F-1:0]  seq_wx_q, seq_wy_q;
  logic [AW-1:0] row0, row1;

  assign row0 = AW'(s3_y0_q) * AW'(MAX_SOURCE_WIDTH);
  assign row1 = AW'(s3_y1_q) * AW'(MAX_SOURCE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_busy_q <= 1'b0;
      seq_cnt_q  <= '0;
    end else if (seq_take) begin
      seq_busy_q <= 1'b1;
      seq_cnt_q  <= '0;
    end else if (seq_busy_q) begin
      seq_cnt_q <= seq_cnt_q + 2'd1;
      if (seq_cnt_q == 2'd3) begin
        seq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take) begin
      seq_addr_q[0] <= row0 + AW'(s3_x0_q);
      seq_addr_q[1] <= row0 + AW'(s3_x1_q);
      seq_addr_q[2] <= row1 + AW'(s3_x0_q);
      seq_addr_q[3] <= row1 + AW'(s3_x1_q);
      seq_wx_q      <= s3_wx_q;
      seq_wy_q      <= s3_wy_q;
    end
  end

  // read tag follows the registered read data
  logic         rd_v_q;
  logic [1:0]   rd_idx_q;
  logic [F-1:0] rd_wx_q, rd_wy_q;
  logic [47:0]  smp_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= seq_busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= seq_cnt_q;
    rd_wx_q  <= seq_wx_q;
    rd_wy_q  <= seq_wy_q;
    if (rd_v_q && (rd_idx_q != 2'd3)) begin
      smp_q[rd_idx_q] <= ram_rdata;
    end
  end

  // ---------------------------------------------------------------- interpolation
  logic           m1_v_q, m2_v_q;
  logic [TW-1:0]  top_q [3];
  logic [TW-1:0]  bot_q [3];
  logic [F-1:0]   m1_wy_q;
  logic [VW2-1:0] v_q [3];
  logic [TW-1:0]  top_c [3];
  logic [TW-1:0]  bot_c [3];
  logic [VW2-1:0] v_c [3];
  logic [F:0]     nwx, nwy;

  assign nwx = {1'b1, {F{1'b0}}} - {1'b0, rd_wx_q};
  assign nwy = {1'b1, {F{1'b0}}} - {1'b0, m1_wy_q};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top_c[c] = TW'(TW'(smp_q[0][47-16*c -: 16]) * TW'(nwx) +
                     TW'(smp_q[1][47-16*c -: 16]) * TW'(rd_wx_q));
      bot_c[c] = TW'(TW'(smp_q[2][47-16*c -: 16]) * TW'(nwx) +
                     TW'(ram_rdata[47-16*c -: 16]) * TW'(rd_wx_q));
      v_c[c]   = VW2'(VW2'(top_q[c]) * VW2'(nwy) + VW2'(bot_q[c]) * VW2'(m1_wy_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else begin
      m1_v_q <= rd_v_q && (rd_idx_q == 2'd3);
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q && (rd_idx_q == 2'd3)) begin
      top_q   <= top_c;
      bot_q   <= bot_c;
      m1_wy_q <= rd_wy_q;
    end
    if (m1_v_q) begin
      v_q <= v_c;
    end
  end

  // ---------------------------------------------------------------- result queue
  // sized for every request the sequencer may have in flight, so the math never stalls
  pix_t                 fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic                 pop;
  pix_t                 head;

  assign out_valid_o = (fifo_cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head        = fifo_q[rd_ptr_q];
  assign red_out_o   = head.red;
  assign green_out_o = head.green;
  assign blue_out_o  = head.blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      if (m2_v_q) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + OUT_CNT_W'(m2_v_q) - OUT_CNT_W'(pop);
      out_cnt_q  <= out_cnt_q + OUT_CNT_W'(seq_take) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (m2_v_q) begin
      fifo_q[wr_ptr_q] <= '{red:   quant(v_q[0], sgn_q),
                            green: quant(v_q[1], sgn_q),
                            blue:  quant(v_q[2], sgn_q)};
    end
  end

`ifndef SYNTHESIS
  // a load must never land while a request still reads the store
  a_no_load_during_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !seq_busy_q)
    else $error("frame store written during neighbour reads");

  a_out_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("too many requests in flight");

  a_fifo_within_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= out_cnt_q)
    else $error("result queue holds more than in flight");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_x |-> ((roi_st_q == R_DIV) && div_done_y))
    else $error("step divider finished outside roi setup");
`endif

endmodule

>>> tb/tb_roi_bilinear_crop_quantizer_core.sv
// self-checking testbench of roi_bilinear_crop_quantizer_core: loads frames, sets crops,
// requests pixels and compares every result beat with an in-bench fixed-point predictor
// depends on rbcq_pkg and the top level only
`timescale 1ns / 100ps

module tb_roi_bilinear_crop_quantizer_core;
  import rbcq_pkg::*;

  localparam int          FRAC_BITS   = DEF_COORD_FRACTION_BITS;
  localparam int          STORE_COLS  = DEF_MAX_SOURCE_WIDTH;
  localparam int          STORE_ROWS  = DEF_MAX_SOURCE_HEIGHT;
  localparam int          IDLE_PCT    = 38;
  localparam int          SETTLE_CYC  = 60;          // covers the roi divider after the last beat
  localparam int          CYCLE_LIMIT = 600000;
  localparam logic [1:0]  KIND_NONE   = 2'd3;        // unused kind, dropped by the block

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  pos_x_i, pos_y_i;
  logic [15:0] red_in_i, green_in_i, blue_in_i;
  logic [15:0] roi_center_x_i, roi_center_y_i, roi_width_i, roi_height_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [8:0] red_out_o, green_out_o, blue_out_o;

  roi_bilinear_crop_quantizer_core u_top (.*);

  // clock and cycle limit
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  int cycle_cnt = 0;
  int err_cnt   = 0;
  bit idle_on   = 1'b1;   // cleared for a stretch with back-to-back beats on both sides

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  // predictor state: registers, crop geometry, frame contents
  logic [8:0]  src_w_q, src_h_q, out_w_q, out_h_q;
  logic [15:0] margin_q;
  logic        signed_q;
  int          org_x_q, org_y_q;
  logic [31:0] step_x_q, step_y_q;
  logic [47:0] frame_q [STORE_COLS*STORE_ROWS];
  bit          loaded_q [STORE_COLS*STORE_ROWS];   // pixels the bench has written so far
  pix_t        pix_expected [$];

  function automatic int clamp_dim(logic [8:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // square crop around the roi, side widened by the margin
  function automatic void crop_from_roi(logic [15:0] cx, logic [15:0] cy,
                                        logic [15:0] rw, logic [15:0] rh);
    longint unsigned sw, sh, ow, oh, bw, bh, side0, side15, sidef;
    sw = clamp_dim(src_w_q, STORE_COLS);
    sh = clamp_dim(src_h_q, STORE_ROWS);
    ow = (out_w_q == 0) ? 1 : out_w_q;
    oh = (out_h_q == 0) ? 1 : out_h_q;
    bw = rw * sw;
    bh = rh * sh;
    side0  = (bw > bh) ? bw : bh;
    side15 = (side0 * (64'd65536 + margin_q) + 64'd32768) >> 16;
    sidef  = 2 * side15;   // coordinate fraction equals 16 bits here
    org_x_q  = sat32(longint'(2 * cx * sw) - longint'(side15));
    org_y_q  = sat32(longint'(2 * cy * sh) - longint'(side15));
    step_x_q = sat32(longint'((sidef + ow / 2) / ow));
    step_y_q = sat32(longint'((sidef + oh / 2) / oh));
  endfunction

  // one axis: two clamped neighbour indexes and the fractional weight
  function automatic void map_axis(int org, logic [31:0] stp, int pos, int lim,
                                   output int i0, output int i1,
                                   output longint unsigned w);
    longint unsigned off;
    longint s, fl, a, b;
    off = ((2 * longint'(pos) + 1) * {32'd0, stp}) >> 1;
    s   = longint'(org) + longint'(off);
    fl  = s >>> FRAC_BITS;
    w   = s & ((64'd1 << FRAC_BITS) - 1);
    a   = fl;
    b   = fl + 1;
    if (a < 0) a = 0; else if (a > lim - 1) a = lim - 1;
    if (b < 0) b = 0; else if (b > lim - 1) b = lim - 1;
    i0 = int'(a);
    i1 = int'(b);
  endfunction

  function automatic longint round_half_even(longint unsigned n, int sh);
    longint unsigned q, r, half;
    q    = n >> sh;
    r    = n & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (r > half || (r == half && q[0])) q++;
    return longint'(q);
  endfunction

  function automatic logic signed [8:0] quantize(longint unsigned v);
    int     sh;
    longint q;
    sh = 15 + 2 * FRAC_BITS;
    if (v > (64'd1 << (sh + 1))) v = 64'd1 << (sh + 1);   // limit at 2.0
    if (signed_q) begin
      q = round_half_even(254 * v, sh) - 127;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
    end else begin
      q = round_half_even(255 * v + (64'd1 << (sh - 1)), sh);
      if (q > 255) q = 255;
      if (q < 0) q = 0;
    end
    return q[8:0];
  endfunction

  function automatic pix_t resample_pixel(int px, int py);
    int x0, x1, y0, y1;
    longint unsigned wx, wy, one, s00, s01, s10, s11, v;
    logic signed [8:0] ch [3];
    pix_t p;
    one = 64'd1 << FRAC_BITS;
    map_axis(org_x_q, step_x_q, px, clamp_dim(src_w_q, STORE_COLS), x0, x1, wx);
    map_axis(org_y_q, step_y_q, py, clamp_dim(src_h_q, STORE_ROWS), y0, y1, wy);
    for (int c = 0; c < 3; c++) begin
      // channel c sits at bits [47-16c -: 16]: red, green, blue
      s00 = frame_q[y0 * STORE_COLS + x0][47 - 16 * c -: 16];
      s01 = frame_q[y0 * STORE_COLS + x1][47 - 16 * c -: 16];
      s10 = frame_q[y1 * STORE_COLS + x0][47 - 16 * c -: 16];
      s11 = frame_q[y1 * STORE_COLS + x1][47 - 16 * c -: 16];
      v = (s00 * (one - wx) + s01 * wx) * (one - wy) + (s10 * (one - wx) + s11 * wx) * wy;
      ch[c] = quantize(v);
    end
    p.red   = ch[0];
    p.green = ch[1];
    p.blue  = ch[2];
    return p;
  endfunction

  // input side: one beat, predictor updated at its acceptance edge
  task automatic send_beat(logic [1:0] k, logic [7:0] px, logic [7:0] py,
                           logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] cx, logic [15:0] cy,
                           logic [15:0] rw, logic [15:0] rh);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    pos_x_i        <= px;
    pos_y_i        <= py;
    red_in_i       <= r;
    green_in_i     <= g;
    blue_in_i      <= b;
    roi_center_x_i <= cx;
    roi_center_y_i <= cy;
    roi_width_i    <= rw;
    roi_height_i   <= rh;
    do @(posedge clk_i); while (!in_ready_o);
    case (k)
      KIND_LOAD: begin
        frame_q[py * STORE_COLS + px]  = {r, g, b};
        loaded_q[py * STORE_COLS + px] = 1'b1;
      end
      KIND_ROI:   crop_from_roi(cx, cy, rw, rh);
      KIND_PIXEL: pix_expected.push_back(resample_pixel(px, py));
      default: ;
    endcase
  endtask

  task automatic load_pixel(int px, int py, logic [15:0] r, logic [15:0] g, logic [15:0] b);
    send_beat(KIND_LOAD, px[7:0], py[7:0], r, g, b, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic set_roi(logic [15:0] cx, logic [15:0] cy, logic [15:0] rw, logic [15:0] rh);
    send_beat(KIND_ROI, $urandom, $urandom, $urandom, $urandom, $urandom, cx, cy, rw, rh);
  endtask

  task automatic request_pixel(int px, int py);
    send_beat(KIND_PIXEL, px[7:0], py[7:0], $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  // sender stops until every result has come back, then lets the divider settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pix_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // all six registers, written back to back while the block is idle
  task automatic write_regs(logic [8:0] sw, logic [8:0] sh, logic [8:0] ow, logic [8:0] oh,
                            logic [15:0] margin, logic sgn);
    logic [CFG_DATA_W-1:0] val [6];
    cfg_reg_e idx [6];
    drain();
    idx = '{REG_SRC_W, REG_SRC_H, REG_OUT_W, REG_OUT_H, REG_MARGIN, REG_SIGNED};
    val = '{{7'd0, sw}, {7'd0, sh}, {7'd0, ow}, {7'd0, oh}, margin, {15'd0, sgn}};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    src_w_q  = sw;
    src_h_q  = sh;
    out_w_q  = ow;
    out_h_q  = oh;
    margin_q = margin;
    signed_q = sgn;
  endtask

  // sample values: zero, one, full scale, and random over the full range and up to one
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hffff;
      3:       return $urandom;
      default: return $urandom_range(32768);
    endcase
  endfunction

  function automatic logic [15:0] rand_roi_val();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return $urandom;
      default: return $urandom_range(32768);
    endcase
  endfunction

  // every pixel the block may read under the current source size gets written
  task automatic fill_frame();
    int sw, sh;
    sw = clamp_dim(src_w_q, STORE_COLS);
    sh = clamp_dim(src_h_q, STORE_ROWS);
    for (int y = 0; y < sh; y++)
      for (int x = 0; x < sw; x++)
        if (!loaded_q[y * STORE_COLS + x])
          load_pixel(x, y, rand_sample(), rand_sample(), rand_sample());
  endtask

  // result side: random stalls, each beat checked against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid_o && out_ready_i) begin
        if (pix_expected.size() == 0) begin
          $display("%0t unexpected pixel beat: got r=%0d g=%0d b=%0d", $time,
                   red_out_o, green_out_o, blue_out_o);
          err_cnt++;
        end else begin
          pix_t want;
          want = pix_expected.pop_front();
          if (red_out_o !== want.red) begin
            $display("%0t red mismatch: expected %0d actual %0d", $time, want.red, red_out_o);
            err_cnt++;
          end
          if (green_out_o !== want.green) begin
            $display("%0t green mismatch: expected %0d actual %0d", $time,
                     want.green, green_out_o);
            err_cnt++;
          end
          if (blue_out_o !== want.blue) begin
            $display("%0t blue mismatch: expected %0d actual %0d", $time,
                     want.blue, blue_out_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // after reset: default registers, no crop yet, every request lands on pixel (0,0)
  task automatic test_reset_crop();
    load_pixel(0, 0, 16'd32768, 16'd0, 16'd16384);
    load_pixel(1, 0, 16'd0, 16'd0, 16'd0);
    load_pixel(0, 1, 16'd0, 16'd0, 16'd0);
    load_pixel(1, 1, 16'd0, 16'd0, 16'd0);
    request_pixel(0, 0);
    request_pixel(255, 255);
    send_beat(KIND_NONE, 8'd0, 8'd0, 16'hffff, 16'hffff, 16'hffff,
              16'hffff, 16'hffff, 16'hffff, 16'hffff);
    request_pixel(128, 7);
  endtask

  // tiny frame with extreme samples, degenerate and oversized crops, both quantizers
  task automatic test_corners();
    write_regs(9'd2, 9'd2, 9'd1, 9'd256, 16'hffff, 1'b0);
    load_pixel(0, 0, 16'd0, 16'd32768, 16'hffff);
    load_pixel(1, 0, 16'd32768, 16'hffff, 16'd0);
    load_pixel(0, 1, 16'hffff, 16'd0, 16'd32768);
    load_pixel(1, 1, 16'h7fff, 16'd1, 16'h8000);
    set_roi(16'd0, 16'd0, 16'd0, 16'd0);        // zero side: one point
    request_pixel(0, 0);
    set_roi(16'd16384, 16'd16384, 16'd32768, 16'd0);
    request_pixel(0, 0);
    request_pixel(0, 255);
    request_pixel(255, 0);                      // beyond the crop, grid continues
    set_roi(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    request_pixel(0, 128);
    write_regs(9'd2, 9'd2, 9'd0, 9'd0, 16'd0, 1'b1);
    request_pixel(3, 3);                        // crop kept from before the register change
    set_roi(16'd16384, 16'd16384, 16'd32768, 16'd32768);
    request_pixel(0, 0);
    request_pixel(1, 0);
    request_pixel(255, 255);
  endtask

  task automatic run_frame(logic [8:0] sw, logic [8:0] sh, logic [8:0] ow, logic [8:0] oh,
                           logic [15:0] margin, logic sgn, int n_beats);
    int pick, lim_x, lim_y;
    write_regs(sw, sh, ow, oh, margin, sgn);
    fill_frame();
    lim_x = clamp_dim(sw, STORE_COLS);
    lim_y = clamp_dim(sh, STORE_ROWS);
    for (int i = 0; i < n_beats; i++) begin
      pick = $urandom_range(99);
      if (i == n_beats / 2) drain();            // pause until the block is empty
      if (pick < 60) begin
        if ($urandom_range(3) == 0) request_pixel($urandom_range(255), $urandom_range(255));
        else request_pixel($urandom_range(out_w_q), $urandom_range(out_h_q));
      end else if (pick < 75) begin
        set_roi(rand_roi_val(), rand_roi_val(), rand_roi_val(), rand_roi_val());
      end else if (pick < 95) begin
        load_pixel($urandom_range(lim_x - 1), $urandom_range(lim_y - 1),
                   rand_sample(), rand_sample(), rand_sample());
      end else if (pick < 98) begin
        load_pixel($urandom_range(255), $urandom_range(255),
                   rand_sample(), rand_sample(), rand_sample());
      end else begin
        send_beat(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_random_frames();
    run_frame(9'd4, 9'd4, 9'd4, 9'd4, 16'd13107, 1'b0, 90);
    run_frame(9'd16, 9'd12, 9'd0, 9'd511, 16'd0, 1'b1, 110);
    idle_on = 1'b0;                             // back-to-back stretch
    run_frame(9'd256, 9'd1, 9'd256, 9'd1, 16'hffff, 1'b0, 110);
    idle_on = 1'b1;
    run_frame(9'd511, 9'd0, 9'd300, 9'd3, 16'h8000, 1'b1, 80);
    run_frame(9'd1, 9'd256, 9'd1, 9'd160, 16'd13107, 1'b0, 80);
    run_frame(9'd0, 9'd511, 9'd17, 9'd255, 16'd1, 1'b1, 80);
    for (int i = 0; i < 4; i++)
      run_frame($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(511),
                $urandom_range(511), $urandom, $urandom_range(1), 70);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_SRC_W;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    kind_i         <= KIND_LOAD;
    pos_x_i        <= '0;
    pos_y_i        <= '0;
    red_in_i       <= '0;
    green_in_i     <= '0;
    blue_in_i      <= '0;
    roi_center_x_i <= '0;
    roi_center_y_i <= '0;
    roi_width_i    <= '0;
    roi_height_i   <= '0;
    src_w_q  = RST_SRC_W;
    src_h_q  = RST_SRC_H;
    out_w_q  = RST_OUT_W;
    out_h_q  = RST_OUT_H;
    margin_q = RST_MARGIN;
    signed_q = RST_SIGNED;
    org_x_q  = 0;
    org_y_q  = 0;
    step_x_q = '0;
    step_y_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_crop();
    test_corners();
    test_random_frames();

    // wind down: every prediction consumed, then let the divider settle
    in_valid_i <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
